>>> src/tki_pkg.sv
`timescale 1ns / 1ps
package tki_pkg;

  typedef struct packed {
    logic signed [15:0] score;
    logic [9:0]         x;
    logic [9:0]         y;
    logic signed [10:0] dtag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  localparam logic [1:0] OP_INSERT      = 2'd0;
  localparam logic [1:0] OP_INSERT_EMIT = 2'd1;
  localparam logic [1:0] OP_EMIT        = 2'd2;

  localparam logic [3:0] K_RESET = 4'd8;

  function automatic logic [3:0] clamp_k(input logic [3:0] v, input logic [3:0] cap);
    logic [3:0] k;
    k = v;
    if (k == 4'd0) k = 4'd1;
    if (k > cap) k = cap;
    return k;
  endfunction

endpackage

>>> src/tki_cell.sv
`timescale 1ns / 1ps
module tki_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tki_pkg::cell_ctl_t ctl,
  input  tki_pkg::entry_t    cand,
  input  tki_pkg::entry_t    up_ent,
  input  logic               up_valid,
  input  logic               up_lose,
  input  tki_pkg::entry_t    dn_ent,
  input  logic               dn_valid,
  output tki_pkg::entry_t    ent_o,
  output logic               valid_o,
  output logic               lose_o
);
  import tki_pkg::*;

  entry_t ent_r, ent_nxt;
  logic   valid_r, valid_nxt;

  assign valid_o = valid_r & en;
  assign ent_o   = ent_r;
  assign lose_o  = en && (!valid_o || ($signed(cand.score) > $signed(ent_r.score)));

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    priority if (!en) begin
      valid_nxt = 1'b0;
    end else if (ctl.pop) begin
      ent_nxt   = dn_ent;
      valid_nxt = dn_valid;
    end else if (ctl.ins && lose_o) begin
      if (up_lose) begin
        ent_nxt   = up_ent;
        valid_nxt = up_valid;
      end else begin
        ent_nxt   = cand;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> src/top_k_ranked_insert.sv
`timescale 1ns / 1ps
// channel   dir  handshake               payload
// in_       in   in_tvalid/in_tready     tdata score,x,y,dist; tuser opcode
// out_      out  out_tvalid/out_tready   tdata rank,score,x,y,dist; tuser valid_res; tlast
// cfg_      in   cfg_valid/cfg_ready     cfg_data k_limit
//
// an insert beat: every enabled cell compares and shifts in parallel
// an emit pops one retained entry per output beat (one zero beat for an empty list) as the
// cells shift up toward the output register; no input beat is taken meanwhile
// reset empties the list and sets k_limit to 8, capped at MAX_DEPTH; config is always ready
// a stalled output beat holds the emit; once the last beat is loaded, inputs go in
module top_k_ranked_insert #(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cand_score, cand_x, cand_y, cand_dist, zero pad
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // rank, out_score, out_x, out_y, out_dist, zero pad
  output logic [0:0]  out_tuser,  // valid_res
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import tki_pkg::*;

  localparam logic [3:0] K_CAP = (MAX_DEPTH < 8) ? 4'(MAX_DEPTH) : 4'd8;

  state_t     state_r, state_nxt;
  logic [3:0] keff_r;
  logic [2:0] rank_r, rank_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [55:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;
  logic        out_tlast_r, out_tlast_nxt;

  cell_ctl_t ctl;
  entry_t    cand;
  logic      in_acc, slot_free;

  entry_t                 ent_chain   [MAX_DEPTH:0];
  logic   [MAX_DEPTH:0]   valid_chain;
  logic   [MAX_DEPTH-1:0] lose_chain;
  logic   [MAX_DEPTH-1:0] cell_en;

  assign cand.score = in_tdata[15:0];
  assign cand.x     = in_tdata[25:16];
  assign cand.y     = in_tdata[35:26];
  assign cand.dtag  = in_tdata[46:36];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_tvalid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign ent_chain[MAX_DEPTH]   = '0;
  assign valid_chain[MAX_DEPTH] = 1'b0;

  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    entry_t up_ent;
    logic   up_valid, up_lose;
    if (g == 0) begin : g_head
      assign up_ent   = cand;
      assign up_valid = 1'b0;
      assign up_lose  = 1'b0;
    end else begin : g_body
      assign up_ent   = ent_chain[g-1];
      assign up_valid = valid_chain[g-1];
      assign up_lose  = lose_chain[g-1];
    end
    assign cell_en[g] = (g < int'(keff_r));
    tki_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (cell_en[g]),
      .ctl      (ctl),
      .cand     (cand),
      .up_ent   (up_ent),
      .up_valid (up_valid),
      .up_lose  (up_lose),
      .dn_ent   (ent_chain[g+1]),
      .dn_valid (valid_chain[g+1]),
      .ent_o    (ent_chain[g]),
      .valid_o  (valid_chain[g]),
      .lose_o   (lose_chain[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    rank_nxt       = rank_r;
    ctl.ins        = 1'b0;
    ctl.pop        = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            OP_INSERT: ctl.ins = 1'b1;
            OP_INSERT_EMIT: begin
              ctl.ins   = 1'b1;
              state_nxt = ST_EMIT;
            end
            OP_EMIT: state_nxt = ST_EMIT;
            default: ;
          endcase
          rank_nxt = 3'd0;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          if (valid_chain[0]) begin
            ctl.pop       = 1'b1;
            out_tdata_nxt = {6'd0, ent_chain[0].dtag, ent_chain[0].y, ent_chain[0].x,
                             ent_chain[0].score, rank_r};
            out_tuser_nxt = 1'b1;
            out_tlast_nxt = !valid_chain[1];
            rank_nxt      = rank_r + 3'd1;
            if (!valid_chain[1]) state_nxt = ST_IDLE;
          end else begin
            out_tdata_nxt = '0;
            out_tuser_nxt = 1'b0;
            out_tlast_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rank_r       <= 3'd0;
      out_tvalid_r <= 1'b0;
      keff_r       <= clamp_k(K_RESET, K_CAP);
    end else begin
      state_r      <= state_nxt;
      rank_r       <= rank_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) keff_r <= clamp_k(cfg_data, K_CAP);
    end
  end

endmodule

>>> src/tki_checker.sv
`timescale 1ns / 1ps
module tki_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
                                  && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // empty-list beat is all zero and closes the emit
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 56'd0))
    else $error("empty-list beat malformed");

  // a nonzero rank only on a retained entry
  a_rank_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != 3'd0) |-> out_tuser[0])
    else $error("ranked beat without valid_res");

  // input is held off while an emit is still running
  a_emit_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken in the middle of an emit");

endmodule

bind top_k_ranked_insert tki_checker u_tki_checker (.*);
